>>> rtl/core/torque_speed_reference_ramp_defines.svh
// Assertion macros used by the checker of the torque and speed reference ramp.
`ifndef TORQUE_SPEED_REFERENCE_RAMP_DEFINES_SVH
`define TORQUE_SPEED_REFERENCE_RAMP_DEFINES_SVH

// Same-cycle implication, sampled on the rising clock edge, off while in reset.
`define TSRR_ASSERT_NOW(name, clk, rst_n, ante, cons, msg) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, sampled on the rising clock edge, off while in reset.
`define TSRR_ASSERT_NEXT(name, clk, rst_n, ante, cons, msg) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

>>> rtl/core/tsrr_pkg.sv
// Types and constants shared by the torque and speed reference ramp modules.
`default_nettype none

package tsrr_pkg;

  // Field widths.
  localparam int SAMPLE_W   = 12;
  localparam int CFG15_W    = 15;
  localparam int SPD_DLT_W  = 16;
  localparam int TORQUE_W   = 16;
  localparam int SPEED_W    = 24;
  localparam int RPM_W      = 16;
  localparam int SRC_W      = 2;

  // Register port geometry.
  localparam int ADDR_W     = 5;
  localparam int DATA_W     = 32;
  localparam int NUM_REGS   = 5;

  // Register indexes.
  localparam logic [2:0] REG_MAX_TORQUE   = 3'd0;
  localparam logic [2:0] REG_TORQUE_DELTA = 3'd1;
  localparam logic [2:0] REG_MAX_SPEED    = 3'd2;
  localparam logic [2:0] REG_SPEED_DELTA  = 3'd3;
  localparam logic [2:0] REG_SPEED_STEP   = 3'd4;

  // Torque source codes.
  localparam logic [SRC_W-1:0] SRC_SLIDER = 2'd0;
  localparam logic [SRC_W-1:0] SRC_PEDAL  = 2'd1;
  localparam logic [SRC_W-1:0] SRC_HOST   = 2'd2;

  // Per-tick fields that travel down the pipeline beside the ADC scaling.
  typedef struct packed {
    logic                     running;
    logic                     source_press;
    logic                     mode_press;
    logic                     speed_up;
    logic                     speed_down;
    logic signed [TORQUE_W-1:0] host_torque;
    logic signed [RPM_W-1:0]    rotor_rpm;
    logic                     clear_change;
  } item_t;

  // Stage load enables handed to the ADC scaling lanes.
  typedef struct packed {
    logic ld_prod;
    logic ld_est;
    logic ld_fix;
  } scale_ctl_t;

endpackage

`default_nettype wire

>>> rtl/core/tsrr_scale.sv
// Three-stage ADC scaling lane: sample * max_torque / ADC_FULL_SCALE, truncated and saturated to 16 bits.
`default_nettype none

module tsrr_scale #(
  parameter int ADC_FULL_SCALE = 4095
) (
  input  logic                              clk,
  input  tsrr_pkg::scale_ctl_t              ctl,
  input  logic [tsrr_pkg::SAMPLE_W-1:0]     sample,
  input  logic [tsrr_pkg::CFG15_W-1:0]      max_torque,
  output logic [tsrr_pkg::TORQUE_W-1:0]     target
);

  // Product width and the reciprocal of the full-scale value.
  localparam int PW = tsrr_pkg::SAMPLE_W + tsrr_pkg::CFG15_W;
  localparam longint unsigned RECIP = (64'd1 << PW) / ADC_FULL_SCALE;
  localparam int RW = $clog2(RECIP + 1);
  localparam longint unsigned Q_MAX = ((64'd1 << PW) - 1) / ADC_FULL_SCALE;
  localparam int QW = $clog2(Q_MAX + 1);
  localparam logic [RW-1:0] RECIP_C = RW'(RECIP);
  localparam logic [PW-1:0] FS = PW'(ADC_FULL_SCALE);

  logic [PW-1:0]    prod_r;
  logic [PW-1:0]    prod_nxt;
  logic [PW-1:0]    prod2_r;
  logic [PW+RW-1:0] est_wide;
  logic [QW-1:0]    est_r;
  logic [QW-1:0]    est_nxt;
  logic [PW-1:0]    back;
  logic [PW-1:0]    rem;
  logic [QW:0]      quot;
  logic [31:0]      quot_wide;
  logic [tsrr_pkg::TORQUE_W-1:0] target_r;
  logic [tsrr_pkg::TORQUE_W-1:0] target_nxt;

  // Stage one: the raw product.
  assign prod_nxt = {{(PW-tsrr_pkg::SAMPLE_W){1'b0}}, sample}
                  * {{(PW-tsrr_pkg::CFG15_W){1'b0}}, max_torque};

  // Stage two: quotient estimate, low by at most one.
  assign est_wide = {{RW{1'b0}}, prod_r} * {{PW{1'b0}}, RECIP_C};
  assign est_nxt  = est_wide[PW+QW-1:PW];

  // Stage three: correct the estimate by one compare, then saturate to 16 bits.
  // Any target above 16 bits steers the ramp the same way as 65535.
  always_comb begin
    back      = {{(PW-QW){1'b0}}, est_r} * FS;
    rem       = prod2_r - back;
    quot      = {1'b0, est_r} + {{QW{1'b0}}, (rem >= FS)};
    quot_wide = {{(32-QW-1){1'b0}}, quot};
    if (quot_wide > 32'h0000_FFFF) begin
      target_nxt = 16'hFFFF;
    end else begin
      target_nxt = quot_wide[tsrr_pkg::TORQUE_W-1:0];
    end
  end

  // Datapath registers advance with the top-level pipeline.
  always_ff @(posedge clk) begin
    if (ctl.ld_prod) begin
      prod_r <= prod_nxt;
    end
    if (ctl.ld_est) begin
      est_r   <= est_nxt;
      prod2_r <= prod_r;
    end
    if (ctl.ld_fix) begin
      target_r <= target_nxt;
    end
  end

  assign target = target_r;

endmodule

`default_nettype wire

>>> rtl/core/torque_speed_reference_ramp.sv
// Top level of the torque and speed reference ramp with its register port.
// One control tick per input transfer; one result per tick. The block takes a
// new tick every clock cycle while the output side does not stall, and returns
// its result through the ADC scaling lanes (product, reciprocal estimate,
// correction), which feed the final stage where the ramp state is read and
// written back as the result is registered.
// Registers sit at byte addresses 4*i: max_torque, torque_delta, max_speed,
// speed_delta, speed_button_step; writes to other addresses are ignored and
// reads of them return zero. Write registers only while no tick is in flight.
`default_nettype none

module torque_speed_reference_ramp #(
  parameter int ADC_FULL_SCALE = 4095
) (
  input  logic                                  clk,
  input  logic                                  rst_n,
  // Register port
  input  logic                                  psel,
  input  logic                                  penable,
  input  logic                                  pwrite,
  input  logic [tsrr_pkg::ADDR_W-1:0]           paddr,
  input  logic [tsrr_pkg::DATA_W-1:0]           pwdata,
  output logic [tsrr_pkg::DATA_W-1:0]           prdata,
  output logic                                  pready,
  // Input channel
  input  logic                                  in_valid,
  output logic                                  in_stall,
  input  logic                                  in_running,
  input  logic                                  in_source_press,
  input  logic                                  in_mode_press,
  input  logic                                  in_speed_up,
  input  logic                                  in_speed_down,
  input  logic [tsrr_pkg::SAMPLE_W-1:0]         in_slider_sample,
  input  logic [tsrr_pkg::SAMPLE_W-1:0]         in_pedal_sample,
  input  logic signed [tsrr_pkg::TORQUE_W-1:0]  in_host_torque,
  input  logic signed [tsrr_pkg::RPM_W-1:0]     in_rotor_rpm,
  input  logic                                  in_clear_change,
  // Result channel
  output logic                                  out_valid,
  input  logic                                  out_stall,
  output logic signed [tsrr_pkg::TORQUE_W-1:0]  out_torque_ref,
  output logic signed [tsrr_pkg::SPEED_W-1:0]   out_speed_ref,
  output logic [tsrr_pkg::SRC_W-1:0]            out_active_source,
  output logic                                  out_cruise_on,
  output logic                                  out_change_pending
);

  localparam int TW = tsrr_pkg::TORQUE_W + 2;  // torque ramp arithmetic
  localparam int SW = tsrr_pkg::SPEED_W + 2;   // speed ramp arithmetic

  // Configuration registers.
  logic [tsrr_pkg::CFG15_W-1:0]   max_torque_r;
  logic [tsrr_pkg::CFG15_W-1:0]   torque_delta_r;
  logic [tsrr_pkg::CFG15_W-1:0]   max_speed_r;
  logic [tsrr_pkg::SPD_DLT_W-1:0] speed_delta_r;
  logic [tsrr_pkg::CFG15_W-1:0]   speed_step_r;
  logic [2:0]                     reg_idx;
  logic                           cfg_wr;

  // Pipeline control.
  logic v1_r, v2_r, v3_r, v4_r, out_valid_r;
  logic rdy1, rdy2, rdy3, rdy4, rdy_o;
  logic ld1, ld2, ld3, ld4, ldo;
  tsrr_pkg::scale_ctl_t scale_ctl;

  // Pipeline payload.
  tsrr_pkg::item_t               item1_r, item2_r, item3_r, item4_r;
  logic [tsrr_pkg::SAMPLE_W-1:0] slider1_r, pedal1_r;
  logic [tsrr_pkg::TORQUE_W-1:0] slider_tgt, pedal_tgt;

  // Ramp state.
  logic [tsrr_pkg::SRC_W-1:0]          src_sel_r, src_sel_nxt;
  logic                                cruise_r, cruise_nxt;
  logic signed [tsrr_pkg::TORQUE_W-1:0] torque_now_r, torque_now_nxt;
  logic signed [tsrr_pkg::SPEED_W-1:0]  speed_now_r, speed_now_nxt;
  logic signed [tsrr_pkg::RPM_W-1:0]    speed_tgt_r, speed_tgt_nxt;
  logic                                flag_r, flag_nxt;

  // Result registers.
  logic signed [tsrr_pkg::TORQUE_W-1:0] torque_out_r;
  logic signed [tsrr_pkg::SPEED_W-1:0]  speed_out_r;
  logic [tsrr_pkg::SRC_W-1:0]           src_out_r;
  logic                                 cruise_out_r;
  logic                                 flag_out_r;

  // Final-stage temporaries.
  logic [tsrr_pkg::SRC_W-1:0]           sel_norm;
  logic                                 press;
  logic                                 run;
  logic                                 cruise_base;
  logic                                 flag_base;
  logic signed [tsrr_pkg::TORQUE_W-1:0] torque_base;
  logic signed [tsrr_pkg::SPEED_W-1:0]  speed_base;
  logic signed [TW-1:0]                 t_target, t_base, t_delta, t_up, t_dn, t_step, t_cap;
  logic signed [TW-1:0]                 t_res;
  logic signed [tsrr_pkg::RPM_W-1:0]    st_up, st_both, rpm_abs;
  logic signed [SW-1:0]                 s_target, s_base, s_delta, s_up, s_dn, s_step, s_cap;
  logic signed [SW-1:0]                 s_res;

  // Saturate an 18-bit signed value to signed 16 bits.
  function automatic logic signed [tsrr_pkg::TORQUE_W-1:0] sat16(input logic signed [TW-1:0] v);
    logic signed [tsrr_pkg::TORQUE_W-1:0] r;
    if (v > 18'sd32767) begin
      r = 16'sh7FFF;
    end else if (v < -18'sd32768) begin
      r = 16'sh8000;
    end else begin
      r = v[tsrr_pkg::TORQUE_W-1:0];
    end
    return r;
  endfunction

  // Register port: write on the access phase, read back any time.
  assign pready  = 1'b1;
  assign cfg_wr  = psel && penable && pwrite;
  assign reg_idx = paddr[tsrr_pkg::ADDR_W-1:2];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      max_torque_r   <= 15'd5120;
      torque_delta_r <= 15'd3;
      max_speed_r    <= 15'd3000;
      speed_delta_r  <= 16'd13;
      speed_step_r   <= 15'd100;
    end else if (cfg_wr) begin
      unique case (reg_idx)
        tsrr_pkg::REG_MAX_TORQUE:   max_torque_r   <= pwdata[tsrr_pkg::CFG15_W-1:0];
        tsrr_pkg::REG_TORQUE_DELTA: torque_delta_r <= pwdata[tsrr_pkg::CFG15_W-1:0];
        tsrr_pkg::REG_MAX_SPEED:    max_speed_r    <= pwdata[tsrr_pkg::CFG15_W-1:0];
        tsrr_pkg::REG_SPEED_DELTA:  speed_delta_r  <= pwdata[tsrr_pkg::SPD_DLT_W-1:0];
        tsrr_pkg::REG_SPEED_STEP:   speed_step_r   <= pwdata[tsrr_pkg::CFG15_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (reg_idx)
      tsrr_pkg::REG_MAX_TORQUE:   prdata = {17'd0, max_torque_r};
      tsrr_pkg::REG_TORQUE_DELTA: prdata = {17'd0, torque_delta_r};
      tsrr_pkg::REG_MAX_SPEED:    prdata = {17'd0, max_speed_r};
      tsrr_pkg::REG_SPEED_DELTA:  prdata = {16'd0, speed_delta_r};
      tsrr_pkg::REG_SPEED_STEP:   prdata = {17'd0, speed_step_r};
      default:                    prdata = '0;
    endcase
  end

  // Each stage moves on when it is empty or the stage after it moves on.
  assign rdy_o    = !out_valid_r || !out_stall;
  assign rdy4     = !v4_r || rdy_o;
  assign rdy3     = !v3_r || rdy4;
  assign rdy2     = !v2_r || rdy3;
  assign rdy1     = !v1_r || rdy2;
  assign in_stall = !rdy1;

  assign ld1 = in_valid && rdy1;
  assign ld2 = v1_r && rdy2;
  assign ld3 = v2_r && rdy3;
  assign ld4 = v3_r && rdy4;
  assign ldo = v4_r && rdy_o;

  assign scale_ctl.ld_prod = ld2;
  assign scale_ctl.ld_est  = ld3;
  assign scale_ctl.ld_fix  = ld4;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r        <= 1'b0;
      v2_r        <= 1'b0;
      v3_r        <= 1'b0;
      v4_r        <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (ld1) begin
        v1_r <= 1'b1;
      end else if (ld2) begin
        v1_r <= 1'b0;
      end
      if (ld2) begin
        v2_r <= 1'b1;
      end else if (ld3) begin
        v2_r <= 1'b0;
      end
      if (ld3) begin
        v3_r <= 1'b1;
      end else if (ld4) begin
        v3_r <= 1'b0;
      end
      if (ld4) begin
        v4_r <= 1'b1;
      end else if (ldo) begin
        v4_r <= 1'b0;
      end
      if (ldo) begin
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // Tick fields ride alongside the scaling lanes.
  always_ff @(posedge clk) begin
    if (ld1) begin
      item1_r.running      <= in_running;
      item1_r.source_press <= in_source_press;
      item1_r.mode_press   <= in_mode_press;
      item1_r.speed_up     <= in_speed_up;
      item1_r.speed_down   <= in_speed_down;
      item1_r.host_torque  <= in_host_torque;
      item1_r.rotor_rpm    <= in_rotor_rpm;
      item1_r.clear_change <= in_clear_change;
      slider1_r            <= in_slider_sample;
      pedal1_r             <= in_pedal_sample;
    end
    if (ld2) begin
      item2_r <= item1_r;
    end
    if (ld3) begin
      item3_r <= item2_r;
    end
    if (ld4) begin
      item4_r <= item3_r;
    end
  end

  // Both ADC samples are scaled, since the source is known only at the last stage.
  tsrr_scale #(
    .ADC_FULL_SCALE (ADC_FULL_SCALE)
  ) u_scale_slider (
    .clk        (clk),
    .ctl        (scale_ctl),
    .sample     (slider1_r),
    .max_torque (max_torque_r),
    .target     (slider_tgt)
  );

  tsrr_scale #(
    .ADC_FULL_SCALE (ADC_FULL_SCALE)
  ) u_scale_pedal (
    .clk        (clk),
    .ctl        (scale_ctl),
    .sample     (pedal1_r),
    .max_torque (max_torque_r),
    .target     (pedal_tgt)
  );

  // Source press: rotate the source, zero the references, force torque control, and flag a change while running.
  always_comb begin
    press = item4_r.source_press;
    run   = item4_r.running;
    sel_norm = (src_sel_r > tsrr_pkg::SRC_HOST) ? tsrr_pkg::SRC_SLIDER : src_sel_r;
    if (press) begin
      src_sel_nxt = (sel_norm == tsrr_pkg::SRC_HOST) ? tsrr_pkg::SRC_SLIDER
                                                     : sel_norm + 2'd1;
    end else begin
      src_sel_nxt = sel_norm;
    end
    torque_base = press ? '0 : torque_now_r;
    speed_base  = press ? '0 : speed_now_r;
    cruise_base = press ? 1'b0 : cruise_r;
    flag_base   = flag_r || (press && run);
    flag_nxt    = item4_r.clear_change ? 1'b0 : flag_base;
  end

  // Torque ramp: one delta toward the target, held inside the dead band, capped.
  always_comb begin
    priority if (src_sel_nxt == tsrr_pkg::SRC_HOST) begin
      t_target = {{2{item4_r.host_torque[tsrr_pkg::TORQUE_W-1]}}, item4_r.host_torque};
    end else if (src_sel_nxt == tsrr_pkg::SRC_PEDAL) begin
      t_target = {2'b00, pedal_tgt};
    end else begin
      t_target = {2'b00, slider_tgt};
    end
    t_base  = {{2{torque_base[tsrr_pkg::TORQUE_W-1]}}, torque_base};
    t_delta = {3'b000, torque_delta_r};
    t_cap   = {3'b000, max_torque_r};
    t_up    = t_base + t_delta;
    t_dn    = t_base - t_delta;
    priority if (t_target > t_up) begin
      t_step = t_up;
    end else if (t_target < t_dn) begin
      t_step = t_dn;
    end else begin
      t_step = t_base;
    end
    t_res = (t_step > t_cap) ? t_cap : t_step;
    torque_now_nxt = run ? sat16(t_res) : '0;
  end

  // Speed buttons, then the speed ramp toward the held target, capped.
  always_comb begin
    st_up   = item4_r.speed_up
            ? sat16({{2{speed_tgt_r[tsrr_pkg::RPM_W-1]}}, speed_tgt_r} + {3'b000, speed_step_r})
            : speed_tgt_r;
    st_both = item4_r.speed_down
            ? sat16({{2{st_up[tsrr_pkg::RPM_W-1]}}, st_up} - {3'b000, speed_step_r})
            : st_up;
    s_target = {{2{st_both[tsrr_pkg::RPM_W-1]}}, st_both, 8'd0};
    s_base   = {{2{speed_base[tsrr_pkg::SPEED_W-1]}}, speed_base};
    s_delta  = {10'd0, speed_delta_r};
    s_cap    = {3'b000, max_speed_r, 8'd0};
    s_up     = s_base + s_delta;
    s_dn     = s_base - s_delta;
    priority if (s_target > s_up) begin
      s_step = s_up;
    end else if (s_target < s_dn) begin
      s_step = s_dn;
    end else begin
      s_step = s_target;
    end
    s_res = (s_step > s_cap) ? s_cap : s_step;
    speed_now_nxt = run ? s_res[tsrr_pkg::SPEED_W-1:0] : '0;
  end

  // Mode press: entering cruise holds |rpm|, leaving cruise clears the target.
  always_comb begin
    if (item4_r.rotor_rpm == 16'sh8000) begin
      rpm_abs = 16'sh7FFF;
    end else if (item4_r.rotor_rpm < 16'sd0) begin
      rpm_abs = -item4_r.rotor_rpm;
    end else begin
      rpm_abs = item4_r.rotor_rpm;
    end
    priority if (run && item4_r.mode_press && !cruise_base) begin
      cruise_nxt    = 1'b1;
      speed_tgt_nxt = rpm_abs;
    end else if (run && item4_r.mode_press) begin
      cruise_nxt    = 1'b0;
      speed_tgt_nxt = '0;
    end else if (run) begin
      cruise_nxt    = cruise_base;
      speed_tgt_nxt = st_both;
    end else begin
      cruise_nxt    = cruise_base;
      speed_tgt_nxt = speed_tgt_r;
    end
  end

  // State and result registers load together when the last stage transfers out.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      src_sel_r    <= tsrr_pkg::SRC_SLIDER;
      cruise_r     <= 1'b0;
      torque_now_r <= '0;
      speed_now_r  <= '0;
      speed_tgt_r  <= '0;
      flag_r       <= 1'b0;
    end else if (ldo) begin
      src_sel_r    <= src_sel_nxt;
      cruise_r     <= cruise_nxt;
      torque_now_r <= torque_now_nxt;
      speed_now_r  <= speed_now_nxt;
      speed_tgt_r  <= speed_tgt_nxt;
      flag_r       <= flag_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (ldo) begin
      torque_out_r <= torque_now_nxt;
      speed_out_r  <= speed_now_nxt;
      src_out_r    <= src_sel_nxt;
      cruise_out_r <= cruise_nxt;
      flag_out_r   <= flag_base;
    end
  end

  assign out_valid          = out_valid_r;
  assign out_torque_ref     = torque_out_r;
  assign out_speed_ref      = speed_out_r;
  assign out_active_source  = src_out_r;
  assign out_cruise_on      = cruise_out_r;
  assign out_change_pending = flag_out_r;

endmodule

`default_nettype wire

>>> rtl/core/tsrr_checker.sv
// Port-level checker for the torque and speed reference ramp, bound to the top level.
`default_nettype none

`include "torque_speed_reference_ramp_defines.svh"

module tsrr_checker (
  input logic                                  clk,
  input logic                                  rst_n,
  input logic                                  psel,
  input logic                                  pwrite,
  input logic [tsrr_pkg::ADDR_W-1:0]           paddr,
  input logic [tsrr_pkg::DATA_W-1:0]           prdata,
  input logic                                  in_stall,
  input logic                                  out_valid,
  input logic                                  out_stall,
  input logic signed [tsrr_pkg::TORQUE_W-1:0]  out_torque_ref,
  input logic signed [tsrr_pkg::SPEED_W-1:0]   out_speed_ref
);

  // A stalled result stays offered and unchanged.
  `TSRR_ASSERT_NEXT(a_out_hold, clk, rst_n, out_valid && out_stall, out_valid && $stable(out_torque_ref) && $stable(out_speed_ref), "stalled result changed")

  // With the output register empty, no pipeline stage can hold up the input.
  `TSRR_ASSERT_NOW(a_in_free, clk, rst_n, !out_valid, !in_stall, "input stalled with empty output")

  // The speed reference never exceeds the largest possible cap.
  `TSRR_ASSERT_NOW(a_speed_cap, clk, rst_n, out_valid, out_speed_ref <= 24'sh7FFF00, "speed reference above cap")

  // Reads beyond the register list return zero.
  `TSRR_ASSERT_NOW(a_rd_hole, clk, rst_n, psel && !pwrite && (paddr[tsrr_pkg::ADDR_W-1:2] >= 3'(tsrr_pkg::NUM_REGS)), prdata == '0, "read of unmapped register not zero")

endmodule

bind torque_speed_reference_ramp tsrr_checker u_tsrr_checker (.*);

`default_nettype wire
